// ===== sv/grid_neighbor_mark_count_macros.svh =====
// assertion macros used by grid_neighbor_mark_count.sv
`ifndef GRID_NEIGHBOR_MARK_COUNT_MACROS_SVH
`define GRID_NEIGHBOR_MARK_COUNT_MACROS_SVH

`ifndef ASSERT_OFF

`define GNMC_CHECK(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("gnmc check failed");

`define GNMC_CHECK_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gnmc implication failed");

`else

`define GNMC_CHECK(label, cond)

`define GNMC_CHECK_IMPL(label, ante, cons)

`endif

`endif

// ===== sv/gnmc_pkg.sv =====
`timescale 1ns / 1ps

package gnmc_pkg;

    // configuration register indexes
    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    // input kind carried on tuser
    localparam logic ACT_CELL  = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    localparam int GRID_WIDTH_RESET  = 8;
    localparam int GRID_HEIGHT_RESET = 8;
    localparam int CFG_DATA_W        = 16;
    localparam int GRID_WIDTH_W      = 11;
    localparam int HEIGHT_W          = 16;
    localparam int ROW_W             = HEIGHT_W + 1;
    localparam int COUNT_W           = 4;
    localparam int LINE_W            = 2;
    localparam int OUT_DEPTH         = 3;

    // per-word control carried from the read stage to the update stage
    typedef struct packed {
        logic col0;
        logic x;
        logic emit;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic last;
    } t_s1_ctl;

    typedef struct packed {
        logic               last;
        logic [COUNT_W-1:0] count;
        logic               marked;
    } t_result;

endpackage

// ===== sv/gnmc_ram.sv =====
`timescale 1ns / 1ps

module gnmc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/grid_neighbor_mark_count.sv =====
`timescale 1ns / 1ps
// grid_neighbor_mark_count: mine count over a binary grid streamed in raster order.
// input stream: tdata[0] = cell mark, tuser = 0 for a grid cell, 1 for a drain word.
// after the last cell of a grid send grid_width+1 drain words to flush the window.
// output stream: tdata[0] = cell marked, tdata[4:1] = marked neighbors (0 when
// marked), tlast on the final cell of the grid. one result per cell, raster order.
// config channel: index 0 = grid width (0 acts as 1, saturates at MAX_WIDTH),
// index 1 = grid height (0 acts as 1); a write restarts the grid. write only idle.
// throughput: one word per clock while tready is high. the two line stores sit in
// one 2-bit wide RAM with a registered read; a word is read in the cycle it is
// accepted and its column is written back in the next cycle, with forwarding when
// the next word hits the same column (width 1, or the first word after a grid ends).
// results: the result for a cell comes with the word grid_width+1 words later and
// is computed in the update stage and held in the output queue before it is valid.
// reset: width returns to min(8, MAX_WIDTH), height to 8, counters and window clear; the
// line store is not cleared, rows not yet written in a grid are masked at the top edge.
// stall: a three-word output queue absorbs a stalled receiver; tready on the
// input drops once the queue and the update stage could not take another word.

`include "grid_neighbor_mark_count_macros.svh"

module grid_neighbor_mark_count #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] cell_marked, [7:1] zero
    input  logic        i_s_axis_tuser,   // [0] action
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] is_marked, [4:1] neighbor_count, [7:5] zero
    output logic        o_m_axis_tlast,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [gnmc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int W_RESET = (gnmc_pkg::GRID_WIDTH_RESET > MAX_WIDTH) ?
                             MAX_WIDTH : gnmc_pkg::GRID_WIDTH_RESET;
    localparam int RW      = gnmc_pkg::ROW_W;
    localparam int HW      = gnmc_pkg::HEIGHT_W;
    localparam int LW      = gnmc_pkg::LINE_W;
    localparam int QD      = gnmc_pkg::OUT_DEPTH;
    localparam int NW      = gnmc_pkg::COUNT_W;

    // configuration
    logic [WW-1:0]                         r_w_eff, n_w_cfg;
    logic [HW-1:0]                         r_h_eff, n_h_cfg;
    logic [gnmc_pkg::GRID_WIDTH_W-1:0]     cfg_w_raw;
    logic                                  cfg_wr;

    // input position
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    // update stage
    logic              r_s1_valid;
    gnmc_pkg::t_s1_ctl r_s1_ctl, n_s1_ctl;
    logic [CW-1:0]     r_s1_addr;
    logic              r_fwd;
    logic [LW-1:0]     r_fwd_data;
    logic [8:0]        r_win, n_win;

    // output queue
    gnmc_pkg::t_result r_q [QD];
    logic [1:0]        r_wr_ptr, r_rd_ptr, r_cnt;

    logic          acc, go, col0, col_wrap, last_in;
    logic [WW-1:0] col_inc;
    logic [RW-1:0] h_ext, h_p1;
    logic [LW-1:0] ram_rdata, rd, wdata;
    logic [2:0]    v, left, mid, right;
    logic [7:0]    nb;
    gnmc_pkg::t_result res;
    logic          push, pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign cfg_w_raw   = i_cfg_data[gnmc_pkg::GRID_WIDTH_W-1:0];

    always_comb begin
        if (cfg_w_raw == '0) begin
            n_w_cfg = WW'(1);
        end else if (32'(cfg_w_raw) > 32'(MAX_WIDTH)) begin
            n_w_cfg = WW'(MAX_WIDTH);
        end else begin
            n_w_cfg = WW'(cfg_w_raw);
        end
        n_h_cfg = (i_cfg_data == '0) ? HW'(1) : HW'(i_cfg_data);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff <= WW'(W_RESET);
            r_h_eff <= HW'(gnmc_pkg::GRID_HEIGHT_RESET);
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                gnmc_pkg::CFG_GRID_WIDTH:  r_w_eff <= n_w_cfg;
                gnmc_pkg::CFG_GRID_HEIGHT: r_h_eff <= n_h_cfg;
                default:                   r_w_eff <= r_w_eff;
            endcase
        end
    end

    // ---------------- read stage ----------------
    assign o_s_axis_tready = ({1'b0, r_cnt} + {2'b0, r_s1_valid}) <= 3'(QD - 1);
    assign acc      = i_s_axis_tvalid && o_s_axis_tready;
    // a drain word before any cell of a grid is dropped
    assign go       = acc && !(i_s_axis_tuser == gnmc_pkg::ACT_DRAIN
                               && r_row == '0 && r_col == '0);
    assign col0     = (r_col == '0);
    assign col_inc  = WW'(r_col) + WW'(1);
    assign col_wrap = (col_inc >= r_w_eff);
    assign h_ext    = RW'(r_h_eff);
    assign h_p1     = h_ext + RW'(1);
    // the final cell comes out with the first word two rows below the last grid row
    assign last_in  = col0 && (r_row == h_p1);

    always_comb begin
        n_s1_ctl.col0    = col0;
        n_s1_ctl.x       = (i_s_axis_tuser == gnmc_pkg::ACT_CELL) && (r_row < h_ext)
                           && i_s_axis_tdata[0];
        n_s1_ctl.emit    = col0 ? (r_row >= RW'(2)) : (r_row >= RW'(1));
        n_s1_ctl.top_ok  = col0 ? (r_row > RW'(2)) : (r_row >= RW'(2));
        n_s1_ctl.bot_ok  = col0 ? (r_row <= h_ext) : (r_row < h_ext);
        n_s1_ctl.left_ok = col0 ? (r_w_eff > WW'(1)) : (r_col >= CW'(2));
        n_s1_ctl.last    = last_in;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (go) begin
            if (last_in) begin
                n_col = '0;
                n_row = '0;
            end else if (col_wrap) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= go;
            // same column written back in this cycle: the RAM returns old data
            r_fwd      <= go && r_s1_valid && (r_s1_addr == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_s1_ctl  <= n_s1_ctl;
            r_s1_addr <= r_col;
        end
        r_fwd_data <= wdata;
    end

    gnmc_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (wdata),
        .i_re    (go),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // ---------------- update stage ----------------
    // line word: [0] two rows up, [1] one row up
    assign rd    = r_fwd ? r_fwd_data : ram_rdata;
    assign v     = {r_s1_ctl.x, rd[1], rd[0]};
    assign wdata = {r_s1_ctl.x, rd[1]};

    always_comb begin
        if (r_s1_ctl.col0) begin
            left  = r_win[5:3];
            mid   = r_win[8:6];
            right = '0;
            n_win = {v, 6'b0};
        end else begin
            n_win = {v, r_win[8:3]};
            left  = n_win[2:0];
            mid   = n_win[5:3];
            right = n_win[8:6];
        end
        if (r_s1_ctl.last) begin
            n_win = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (cfg_wr) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    always_comb begin
        nb = {r_s1_ctl.top_ok & mid[0],
              r_s1_ctl.bot_ok & mid[2],
              r_s1_ctl.left_ok & r_s1_ctl.top_ok & left[0],
              r_s1_ctl.left_ok & left[1],
              r_s1_ctl.left_ok & r_s1_ctl.bot_ok & left[2],
              !r_s1_ctl.col0 & r_s1_ctl.top_ok & right[0],
              !r_s1_ctl.col0 & right[1],
              !r_s1_ctl.col0 & r_s1_ctl.bot_ok & right[2]};
        res.marked = mid[1];
        res.count  = mid[1] ? '0 : NW'($countones(nb));
        res.last   = r_s1_ctl.last;
    end

    // ---------------- output queue ----------------
    assign push            = r_s1_valid && r_s1_ctl.emit;
    assign o_m_axis_tvalid = (r_cnt != '0);
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == 2'(QD - 1)) ? '0 : r_wr_ptr + 2'd1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == 2'(QD - 1)) ? '0 : r_rd_ptr + 2'd1;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= res;
        end
    end

    assign o_m_axis_tdata = {3'b0, r_q[r_rd_ptr].count, r_q[r_rd_ptr].marked};
    assign o_m_axis_tlast = r_q[r_rd_ptr].last;

    // ---------------- checks ----------------
    `GNMC_CHECK(a_queue_room, ({1'b0, r_cnt} + {2'b0, r_s1_valid}) <= 3'(QD))
    `GNMC_CHECK(a_col_in_row, WW'(r_col) < r_w_eff)
    `GNMC_CHECK_IMPL(a_fwd_only_same_col, go && r_s1_valid && (r_s1_addr == r_col), (r_w_eff == WW'(1)) || r_s1_ctl.last)
    `GNMC_CHECK_IMPL(a_last_restarts, r_s1_valid && r_s1_ctl.last, (r_col == '0) && (r_row == '0))

endmodule
